### rtl/bgf_pkg.sv
package bgf_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // position width, fixed by the 7-bit map size registers
    localparam int PW = 7;
    // Q1.16 value width, 65536 = 1.0
    localparam int VW = 17;
    // magnitude of |v2-v1| * |p-p1|, below 2^24
    localparam int MW = 24;
    localparam int CW = $clog2(MW);

    localparam logic [VW-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_MAP_ROWS = 2'd0,
        CFG_MAP_COLS = 2'd1,
        CFG_ROW_STEP = 2'd2,
        CFG_COL_STEP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PW-1:0] p1;
        logic [PW-1:0] p2;
        logic [PW-1:0] p;
        logic [VW-1:0] v1;
        logic [VW-1:0] v2;
    } t_lerp_req;

endpackage

### rtl/bgf_lerp.sv
// v1 + ((v2-v1)*(p-p1)) / (p2-p1), quotient truncated toward zero.
// A multiply state, then a restoring divider at one bit per cycle.
module bgf_lerp import bgf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_lerp_req     i_req,
    output logic          o_done,
    output logic [VW-1:0] o_val
);

    localparam int XW = VW + PW + 2;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } t_lstate;

    t_lstate              r_state;
    logic                 r_done;
    logic [VW-1:0]        r_val;
    logic [VW-1:0]        r_v1;
    logic signed [VW:0]   r_diff;
    logic signed [PW:0]   r_fac;
    logic signed [PW:0]   r_den;
    logic [PW-1:0]        r_den_mag;
    logic                 r_neg;
    logic [MW-1:0]        r_num;
    logic [PW-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;

    logic signed [XW-1:0] prod;
    logic [XW-1:0]        prod_mag;
    logic [PW:0]          den_abs;
    logic [PW:0]          trial;
    logic                 qbit;
    logic [PW:0]          rem_next;
    logic [MW-1:0]        quot;
    logic [XW-1:0]        squot;
    logic [XW-1:0]        sum;

    always_comb begin
        prod     = r_diff * r_fac;
        prod_mag = prod[XW-1] ? XW'(-prod) : XW'(prod);
        den_abs  = r_den[PW] ? (PW+1)'(-r_den) : (PW+1)'(r_den);
        trial    = {r_rem, r_num[MW-1]};
        qbit     = (trial >= {1'b0, r_den_mag});
        rem_next = qbit ? (trial - {1'b0, r_den_mag}) : trial;
        quot     = {r_num[MW-2:0], qbit};
        squot    = r_neg ? XW'(-{{(XW-MW){1'b0}}, quot}) : {{(XW-MW){1'b0}}, quot};
        sum      = XW'(r_v1) + squot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_v1    <= i_req.v1;
                        r_diff  <= $signed({1'b0, i_req.v2}) - $signed({1'b0, i_req.v1});
                        r_fac   <= $signed({1'b0, i_req.p}) - $signed({1'b0, i_req.p1});
                        r_den   <= $signed({1'b0, i_req.p2}) - $signed({1'b0, i_req.p1});
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (r_den == '0) begin
                        r_val   <= r_v1;
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end else begin
                        r_num     <= prod_mag[MW-1:0];
                        r_neg     <= prod[XW-1] ^ r_den[PW];
                        r_den_mag <= den_abs[PW-1:0];
                        r_rem     <= '0;
                        r_cnt     <= '0;
                        r_state   <= L_DIV;
                    end
                end
                L_DIV: begin
                    r_num <= quot;
                    r_rem <= rem_next[PW-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MW - 1)) begin
                        r_val   <= sum[VW-1:0];
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;

endmodule

### rtl/bilinear_grid_fill_unit.sv
// Write and read go through S_WR or S_RD/S_RDW, then S_DONE to the output register;
// clear sweeps every cell in S_CLR first. Fill: filled cells are read and checked;
// an unfilled border cell adds a forward scan to the next filled one plus one interpolation;
// an unfilled interior cell takes four reads and three interpolations.
// One word in flight at a time; the divider (one quotient bit a cycle) sets fill rate.
// Reset: synchronous; a clearing pass over all MAX_ROWS*MAX_COLS cells runs with s_axis_tready low.
module bilinear_grid_fill_unit import bgf_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row[5:0], col[11:6], node_value[28:12]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // cell_value[16:0], cell_filled[17], status[18]
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_CLR   = 20'h00002,
        S_WR    = 20'h00004,
        S_RD    = 20'h00008,
        S_RDW   = 20'h00010,
        S_BRD   = 20'h00020,
        S_BCHK  = 20'h00040,
        S_BSRD  = 20'h00080,
        S_BSCHK = 20'h00100,
        S_BLRP  = 20'h00200,
        S_BLW   = 20'h00400,
        S_BWR   = 20'h00800,
        S_IRD   = 20'h01000,
        S_ICHK  = 20'h02000,
        S_IRQ   = 20'h04000,
        S_ICQ   = 20'h08000,
        S_ILRP  = 20'h10000,
        S_ILW   = 20'h20000,
        S_IWR   = 20'h40000,
        S_DONE  = 20'h80000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    // config registers
    logic [6:0] r_map_rows, r_map_cols;
    logic [5:0] r_row_step, r_col_step;

    // map memory: {filled mark, Q1.16 value}
    logic [VW:0]   r_mem [DEPTH];
    logic [VW:0]   r_rd_data;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [VW:0]   mem_wdata;

    // control
    t_state        r_state, n_state;
    logic [AW-1:0] r_sweep, n_sweep;
    logic          r_clr_out, n_clr_out;
    logic [PW-1:0] r_row, n_row, r_col, n_col;
    logic [VW-1:0] r_val, n_val;
    logic [VW+1:0] r_res, n_res;          // {status, filled, value}
    logic          r_out_valid, n_out_valid;
    logic [VW+1:0] r_out_data, n_out_data;

    // border walk
    logic [1:0]    r_line, n_line;
    logic [PW-1:0] r_p, n_p, r_q, n_q;
    logic [PW-1:0] r_lo_pos, n_lo_pos, r_hi_pos, n_hi_pos;
    logic [VW-1:0] r_lo_val, n_lo_val, r_hi_val, n_hi_val;
    logic          r_hi_ok, n_hi_ok;
    logic [VW-1:0] r_lv, n_lv;

    // interior walk
    logic [PW-1:0] r_r, n_r, r_c, n_c;
    logic [PW-1:0] r_up, n_up, r_down, n_down, r_left, n_left, r_right, n_right;
    logic [1:0]    r_k, n_k, r_ph, n_ph;
    logic [VW-1:0] r_vq [4];
    logic [VW-1:0] r_a1, n_a1, r_a2, n_a2;
    logic          vq_we;

    // lerp unit
    logic          lerp_start, lerp_done;
    t_lerp_req     lerp_req;
    logic [VW-1:0] lerp_val;

    // derived map geometry
    logic [PW-1:0] rows, cols, rs, cs, down0, right0;
    logic          in_map;
    logic          line_vert;
    logic [PW-1:0] line_k, line_len_m1;
    logic [PW:0]   up_rs, left_cs;
    logic [PW+1:0] up_2rs, left_2cs;
    logic [VW-1:0] rd_val;
    logic          rd_mark;
    logic [PW-1:0] rr, rc, wr, wc;
    logic          b_adv, i_adv;

    always_comb begin
        rows = (r_map_rows < PW'(2)) ? PW'(2)
             : ((int'(r_map_rows) > MAX_ROWS) ? PW'(MAX_ROWS) : r_map_rows);
        cols = (r_map_cols < PW'(2)) ? PW'(2)
             : ((int'(r_map_cols) > MAX_COLS) ? PW'(MAX_COLS) : r_map_cols);
        rs = (r_row_step == '0) ? PW'(1) : PW'(r_row_step);
        cs = (r_col_step == '0) ? PW'(1) : PW'(r_col_step);
        down0  = (rs >= rows) ? rows - 1'b1 : rs;
        right0 = (cs >= cols) ? cols - 1'b1 : cs;
        in_map = (PW'(s_axis_tdata[5:0]) < rows) && (PW'(s_axis_tdata[11:6]) < cols);
        // border lines: first row, last row, first column, last column
        line_vert   = r_line[1];
        line_k      = (r_line == 2'd1) ? rows - 1'b1 : ((r_line == 2'd3) ? cols - 1'b1 : '0);
        line_len_m1 = line_vert ? rows - 1'b1 : cols - 1'b1;
        up_rs    = {1'b0, r_up} + {1'b0, rs};
        up_2rs   = {1'b0, up_rs} + {2'b00, rs};
        left_cs  = {1'b0, r_left} + {1'b0, cs};
        left_2cs = {1'b0, left_cs} + {2'b00, cs};
        rd_mark  = r_rd_data[VW];
        rd_val   = rd_mark ? r_rd_data[VW-1:0] : '0;
    end

    // memory address select
    always_comb begin
        rr = r_r;
        rc = r_c;
        case (r_state)
            S_RD: begin
                rr = r_row;
                rc = r_col;
            end
            S_BRD: begin
                rr = line_vert ? r_p : line_k;
                rc = line_vert ? line_k : r_p;
            end
            S_BSRD: begin
                rr = line_vert ? r_q : line_k;
                rc = line_vert ? line_k : r_q;
            end
            S_IRQ: begin
                rr = r_k[1] ? r_down : r_up;
                rc = r_k[0] ? r_right : r_left;
            end
            default: ;
        endcase
        wr = r_r;
        wc = r_c;
        case (r_state)
            S_WR: begin
                wr = r_row;
                wc = r_col;
            end
            S_BWR: begin
                wr = line_vert ? r_p : line_k;
                wc = line_vert ? line_k : r_p;
            end
            default: ;
        endcase
        mem_raddr = cell_addr(rr, rc);
        mem_re = (r_state == S_RD) || (r_state == S_BRD) || (r_state == S_BSRD)
              || (r_state == S_IRD) || (r_state == S_IRQ);
        mem_we = (r_state == S_CLR) || (r_state == S_WR) || (r_state == S_BWR)
              || (r_state == S_IWR);
        case (r_state)
            S_CLR:   mem_waddr = r_sweep;
            default: mem_waddr = cell_addr(wr, wc);
        endcase
        case (r_state)
            S_CLR:   mem_wdata = '0;
            S_WR:    mem_wdata = {1'b1, r_val};
            default: mem_wdata = {1'b1, r_lv};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // lerp operand select
    always_comb begin
        lerp_start = (r_state == S_BLRP) || (r_state == S_ILRP);
        if (r_state == S_BLRP) begin
            lerp_req = '{p1: r_lo_pos, p2: r_hi_pos, p: r_p, v1: r_lo_val, v2: r_hi_val};
        end else if (r_ph == 2'd0) begin
            lerp_req = '{p1: r_left, p2: r_right, p: r_c, v1: r_vq[0], v2: r_vq[1]};
        end else if (r_ph == 2'd1) begin
            lerp_req = '{p1: r_left, p2: r_right, p: r_c, v1: r_vq[2], v2: r_vq[3]};
        end else begin
            lerp_req = '{p1: r_up, p2: r_down, p: r_r, v1: r_a1, v2: r_a2};
        end
    end

    bgf_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lerp_start),
        .i_req   (lerp_req),
        .o_done  (lerp_done),
        .o_val   (lerp_val)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_clr_out   = r_clr_out;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_line      = r_line;
        n_p         = r_p;
        n_q         = r_q;
        n_lo_pos    = r_lo_pos;
        n_lo_val    = r_lo_val;
        n_hi_pos    = r_hi_pos;
        n_hi_val    = r_hi_val;
        n_hi_ok     = r_hi_ok;
        n_lv        = r_lv;
        n_r         = r_r;
        n_c         = r_c;
        n_up        = r_up;
        n_down      = r_down;
        n_left      = r_left;
        n_right     = r_right;
        n_k         = r_k;
        n_ph        = r_ph;
        n_a1        = r_a1;
        n_a2        = r_a2;
        vq_we       = 1'b0;
        b_adv       = 1'b0;
        i_adv       = 1'b0;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_row = PW'(s_axis_tdata[5:0]);
                    n_col = PW'(s_axis_tdata[11:6]);
                    n_val = (s_axis_tdata[28:12] > ONE_Q16) ? ONE_Q16 : s_axis_tdata[28:12];
                    n_res = '0;
                    unique case (t_cmd'(s_axis_tuser))
                        CMD_CLEAR: begin
                            n_sweep   = '0;
                            n_clr_out = 1'b1;
                            n_state   = S_CLR;
                        end
                        CMD_WRITE: begin
                            n_res[VW+1] = !in_map;
                            n_state     = in_map ? S_WR : S_DONE;
                        end
                        CMD_FILL: begin
                            n_line   = '0;
                            n_p      = '0;
                            n_lo_pos = '0;
                            n_lo_val = '0;
                            n_hi_ok  = 1'b0;
                            n_state  = S_BRD;
                        end
                        CMD_READ: begin
                            n_res[VW+1] = !in_map;
                            n_state     = in_map ? S_RD : S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == AW'(DEPTH - 1)) begin
                    n_state = r_clr_out ? S_DONE : S_IDLE;
                end
            end
            S_WR:  n_state = S_DONE;
            S_RD:  n_state = S_RDW;
            S_RDW: begin
                n_res   = {1'b0, rd_mark, rd_val};
                n_state = S_DONE;
            end
            S_BRD: n_state = S_BCHK;
            S_BCHK: begin
                if (rd_mark) begin
                    n_lo_pos = r_p;
                    n_lo_val = rd_val;
                    b_adv    = 1'b1;
                end else if (r_hi_ok && (r_hi_pos > r_p)) begin
                    n_state = S_BLRP;
                end else if (r_p == line_len_m1) begin
                    n_hi_pos = line_len_m1;
                    n_hi_val = '0;
                    n_hi_ok  = 1'b1;
                    n_state  = S_BLRP;
                end else begin
                    n_q     = r_p + 1'b1;
                    n_state = S_BSRD;
                end
            end
            S_BSRD: n_state = S_BSCHK;
            S_BSCHK: begin
                if (rd_mark) begin
                    n_hi_pos = r_q;
                    n_hi_val = rd_val;
                    n_hi_ok  = 1'b1;
                    n_state  = S_BLRP;
                end else if (r_q == line_len_m1) begin
                    // nothing filled further on: line end counts as zero
                    n_hi_pos = line_len_m1;
                    n_hi_val = '0;
                    n_hi_ok  = 1'b1;
                    n_state  = S_BLRP;
                end else begin
                    n_q     = r_q + 1'b1;
                    n_state = S_BSRD;
                end
            end
            S_BLRP: n_state = S_BLW;
            S_BLW: begin
                if (lerp_done) begin
                    n_lv    = lerp_val;
                    n_state = S_BWR;
                end
            end
            S_BWR: begin
                n_lo_pos = r_p;
                n_lo_val = r_lv;
                b_adv    = 1'b1;
            end
            S_IRD: n_state = S_ICHK;
            S_ICHK: begin
                if (rd_mark) begin
                    i_adv = 1'b1;
                end else begin
                    n_k     = '0;
                    n_state = S_IRQ;
                end
            end
            S_IRQ: n_state = S_ICQ;
            S_ICQ: begin
                vq_we = 1'b1;
                n_k   = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_ph    = '0;
                    n_state = S_ILRP;
                end else begin
                    n_state = S_IRQ;
                end
            end
            S_ILRP: n_state = S_ILW;
            S_ILW: begin
                if (lerp_done) begin
                    n_ph = r_ph + 1'b1;
                    if (r_ph == 2'd0) begin
                        n_a1    = lerp_val;
                        n_state = S_ILRP;
                    end else if (r_ph == 2'd1) begin
                        n_a2    = lerp_val;
                        n_state = S_ILRP;
                    end else begin
                        n_lv    = lerp_val;
                        n_state = S_IWR;
                    end
                end
            end
            S_IWR: i_adv = 1'b1;
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // next border cell, next line, or start of the interior pass
        if (b_adv) begin
            if (r_p == line_len_m1) begin
                if (r_line == 2'd3) begin
                    n_r     = '0;
                    n_c     = '0;
                    n_up    = '0;
                    n_left  = '0;
                    n_down  = down0;
                    n_right = right0;
                    n_state = S_IRD;
                end else begin
                    n_line   = r_line + 1'b1;
                    n_p      = '0;
                    n_lo_pos = '0;
                    n_lo_val = '0;
                    n_hi_ok  = 1'b0;
                    n_state  = S_BRD;
                end
            end else begin
                n_p     = r_p + 1'b1;
                n_state = S_BRD;
            end
        end

        // row-major step; node row/column move up when the step boundary is crossed
        if (i_adv) begin
            if (r_c == cols - 1'b1) begin
                n_c     = '0;
                n_left  = '0;
                n_right = right0;
                if (r_r == rows - 1'b1) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_r = r_r + 1'b1;
                    if ({1'b0, r_r} + 1'b1 == up_rs) begin
                        n_up   = up_rs[PW-1:0];
                        n_down = (up_2rs >= (PW+2)'(rows)) ? rows - 1'b1 : up_2rs[PW-1:0];
                    end
                    n_state = S_IRD;
                end
            end else begin
                n_c = r_c + 1'b1;
                if ({1'b0, r_c} + 1'b1 == left_cs) begin
                    n_left  = left_cs[PW-1:0];
                    n_right = (left_2cs >= (PW+2)'(cols)) ? cols - 1'b1 : left_2cs[PW-1:0];
                end
                n_state = S_IRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sweep     <= '0;
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
            r_map_rows  <= 7'd64;
            r_map_cols  <= 7'd64;
            r_row_step  <= 6'd8;
            r_col_step  <= 6'd8;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_clr_out   <= n_clr_out;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAP_ROWS: r_map_rows <= i_cfg_data;
                    CFG_MAP_COLS: r_map_cols <= i_cfg_data;
                    CFG_ROW_STEP: r_row_step <= i_cfg_data[5:0];
                    CFG_COL_STEP: r_col_step <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_val      <= n_val;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_line     <= n_line;
        r_p        <= n_p;
        r_q        <= n_q;
        r_lo_pos   <= n_lo_pos;
        r_lo_val   <= n_lo_val;
        r_hi_pos   <= n_hi_pos;
        r_hi_val   <= n_hi_val;
        r_hi_ok    <= n_hi_ok;
        r_lv       <= n_lv;
        r_r        <= n_r;
        r_c        <= n_c;
        r_up       <= n_up;
        r_down     <= n_down;
        r_left     <= n_left;
        r_right    <= n_right;
        r_k        <= n_k;
        r_ph       <= n_ph;
        r_a1       <= n_a1;
        r_a2       <= n_a2;
        if (vq_we) begin
            r_vq[r_k] <= rd_val;   // unfilled corner counts as zero
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - VW - 2){1'b0}}, r_out_data};

endmodule

### rtl/bgf_checker.sv
module bgf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // out-of-map status never comes with a filled cell
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[18] && m_axis_tdata[17]))
        else $error("status and cell_filled both set");

    // a nonzero value only from a filled cell
    a_val_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[16:0] != 17'd0) |-> m_axis_tdata[17])
        else $error("value without filled mark");

    // value never above 1.0
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("value above one");

    // no new word taken in the cycle right after one was taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted back to back");

endmodule

bind bilinear_grid_fill_unit bgf_checker u_bgf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bgf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = 2'd0;
    logic [6:0]  i_cfg_data = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;   // row[5:0], col[11:6], node_value[28:12]
    logic [1:0]  s_axis_tuser = 2'd0;    // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // cell_value[16:0], cell_filled[17], status[18]

    // no random idling on either side while set
    bit quiet = 1'b0;

    bilinear_grid_fill_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct {
        logic [16:0] value;
        logic        filled;
        logic        status;
    } t_cell_rsp;

    // Shadow copy of the map; predicts the response word of each command.
    class grid_scoreboard;
        logic [16:0] vals [4096];
        bit          marks [4096];
        int          rows_reg = 64, cols_reg = 64, rstep_reg = 8, cstep_reg = 8;
        t_cell_rsp   pending [$];
        int          errors = 0;

        function new();
            foreach (marks[i]) begin
                marks[i] = 1'b0;
                vals[i] = '0;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [6:0] d);
            case (idx)
                CFG_MAP_ROWS: rows_reg = d;
                CFG_MAP_COLS: cols_reg = d;
                CFG_ROW_STEP: rstep_reg = d[5:0];
                CFG_COL_STEP: cstep_reg = d[5:0];
            endcase
        endfunction

        function int n_rows();
            return rows_reg < 2 ? 2 : (rows_reg > 64 ? 64 : rows_reg);
        endfunction

        function int n_cols();
            return cols_reg < 2 ? 2 : (cols_reg > 64 ? 64 : cols_reg);
        endfunction

        function int idx(int r, int c);
            return (r * 64 + c) % 4096;
        endfunction

        function longint cell_val(int r, int c);
            return marks[idx(r, c)] ? longint'(vals[idx(r, c)]) : 0;
        endfunction

        function void store(int r, int c, longint v);
            if (v < 0) v = 0;
            if (v > 65536) v = 65536;
            vals[idx(r, c)] = v[16:0];
            marks[idx(r, c)] = 1'b1;
        endfunction

        // truncating division, same as the hardware divider
        function longint interp(int p1, longint v1, int p2, longint v2, int p);
            longint den;
            den = p2 - p1;
            if (den == 0) return v1;
            return v1 + ((v2 - v1) * (p - p1)) / den;
        endfunction

        function void fill_border(bit vert, int k, int len);
            int r, c, lo, hi;
            longint vlo, vhi;
            for (int p = 0; p < len; p++) begin
                r = vert ? p : k;
                c = vert ? k : p;
                if (marks[idx(r, c)]) continue;
                lo = 0; hi = len - 1; vlo = 0; vhi = 0;
                for (int q = p - 1; q >= 0; q--) begin
                    if (marks[vert ? idx(q, k) : idx(k, q)]) begin
                        lo = q;
                        vlo = vert ? cell_val(q, k) : cell_val(k, q);
                        break;
                    end
                end
                for (int q = p + 1; q < len; q++) begin
                    if (marks[vert ? idx(q, k) : idx(k, q)]) begin
                        hi = q;
                        vhi = vert ? cell_val(q, k) : cell_val(k, q);
                        break;
                    end
                end
                store(r, c, interp(lo, vlo, hi, vhi, p));
            end
        endfunction

        function void fill_map();
            int rows, cols, rs, cs, up, down, left, right;
            longint a1, a2;
            rows = n_rows();
            cols = n_cols();
            rs = rstep_reg == 0 ? 1 : rstep_reg;
            cs = cstep_reg == 0 ? 1 : cstep_reg;
            fill_border(1'b0, 0, cols);
            fill_border(1'b0, rows - 1, cols);
            fill_border(1'b1, 0, rows);
            fill_border(1'b1, cols - 1, rows);
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    if (marks[idx(r, c)]) continue;
                    up = (r / rs) * rs;
                    down = (up + rs >= rows) ? rows - 1 : up + rs;
                    left = (c / cs) * cs;
                    right = (left + cs >= cols) ? cols - 1 : left + cs;
                    a1 = interp(left, cell_val(up, left), right, cell_val(up, right), c);
                    a2 = interp(left, cell_val(down, left), right, cell_val(down, right), c);
                    store(r, c, interp(up, a1, down, a2, r));
                end
            end
        endfunction

        function void note(t_cmd cmd, logic [5:0] r, logic [5:0] c, logic [16:0] v);
            t_cell_rsp rsp;
            bit in_map;
            in_map = (r < n_rows()) && (c < n_cols());
            rsp = '{value: '0, filled: 1'b0, status: 1'b0};
            case (cmd)
                CMD_CLEAR: foreach (marks[i]) marks[i] = 1'b0;
                CMD_WRITE: begin
                    if (!in_map) rsp.status = 1'b1;
                    else store(r, c, v > 65536 ? 65536 : v);
                end
                CMD_FILL: fill_map();
                CMD_READ: begin
                    if (!in_map) rsp.status = 1'b1;
                    else if (marks[idx(r, c)]) begin
                        rsp.value = vals[idx(r, c)];
                        rsp.filled = 1'b1;
                    end
                end
            endcase
            pending.push_back(rsp);
        endfunction

        function void check(logic [23:0] d);
            t_cell_rsp rsp;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", d);
                errors++;
                return;
            end
            rsp = pending.pop_front();
            if (d[16:0] !== rsp.value) begin
                $error("cell_value: expected %0d, got %0d", rsp.value, d[16:0]);
                errors++;
            end
            if (d[17] !== rsp.filled) begin
                $error("cell_filled: expected %0d, got %0d", rsp.filled, d[17]);
                errors++;
            end
            if (d[18] !== rsp.status) begin
                $error("status: expected %0d, got %0d", rsp.status, d[18]);
                errors++;
            end
        endfunction
    endclass

    grid_scoreboard grid = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: stall about 8% of cycles unless quiet
    always @(negedge i_clk)
        m_axis_tready = quiet || ($urandom_range(99) >= 8);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            grid.check(m_axis_tdata);

    // Hard stop; a 64x64 fill alone runs long.
    initial begin
        #50_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_word(t_cmd cmd, int r, int c, int v);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 8) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {3'b0, v[16:0], c[5:0], r[5:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        grid.note(cmd, r[5:0], c[5:0], v[16:0]);
    endtask

    // Wait for all outstanding words, then a short settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (grid.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [6:0] d);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        grid.set_reg(idx, d);
    endtask

    task automatic set_map(logic [6:0] rows, logic [6:0] cols, logic [6:0] rs, logic [6:0] cs);
        write_reg(CFG_MAP_ROWS, rows);
        write_reg(CFG_MAP_COLS, cols);
        write_reg(CFG_ROW_STEP, rs);
        write_reg(CFG_COL_STEP, cs);
    endtask

    // One well-formed job: clear, corners, nodes, some noise, fill, reads.
    task automatic random_job();
        int rows, cols, rs, cs;
        rows = grid.n_rows();
        cols = grid.n_cols();
        rs = grid.rstep_reg == 0 ? 1 : grid.rstep_reg;
        cs = grid.cstep_reg == 0 ? 1 : grid.cstep_reg;
        send_word(CMD_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(131071));
        // usually all four corners, sometimes one skipped to hit the zero fallback
        if ($urandom_range(5) != 0) send_word(CMD_WRITE, 0, 0, $urandom_range(65536));
        send_word(CMD_WRITE, 0, cols - 1, $urandom_range(65536));
        send_word(CMD_WRITE, rows - 1, 0, $urandom_range(65536));
        send_word(CMD_WRITE, rows - 1, cols - 1, $urandom_range(131071));
        repeat ($urandom_range(4)) begin
            send_word(CMD_WRITE, (($urandom_range(rows - 1)) / rs) * rs,
                      (($urandom_range(cols - 1)) / cs) * cs, $urandom_range(65536));
        end
        repeat ($urandom_range(3)) begin
            // noise: any command, any cell, any value
            send_word(t_cmd'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                      $urandom_range(131071));
        end
        send_word(CMD_FILL, $urandom_range(63), $urandom_range(63), $urandom_range(131071));
        repeat (6 + $urandom_range(6)) begin
            if ($urandom_range(7) == 0)
                send_word(CMD_READ, $urandom_range(63), $urandom_range(63), 0);
            else
                send_word(CMD_READ, $urandom_range(rows - 1), $urandom_range(cols - 1),
                          $urandom_range(131071));
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, full 64x64 map at reset settings.
        send_word(CMD_READ, 5, 5, 0);                 // unfilled cell reads zero
        send_word(CMD_WRITE, 0, 0, 0);
        send_word(CMD_WRITE, 0, 63, 65536);
        send_word(CMD_WRITE, 63, 0, 131071);          // above one, saturates
        send_word(CMD_WRITE, 63, 63, 12345);
        send_word(CMD_WRITE, 8, 8, 40000);
        send_word(CMD_READ, 63, 0, 0);
        send_word(CMD_FILL, 0, 0, 0);
        send_word(CMD_READ, 0, 31, 0);
        send_word(CMD_READ, 4, 4, 0);
        send_word(CMD_READ, 62, 62, 0);
        send_word(CMD_CLEAR, 63, 63, 131071);
        send_word(CMD_READ, 8, 8, 0);                 // stored but no longer filled
        drain();

        // Clamped sizes and zero / masked steps, no idling here.
        quiet = 1'b1;
        set_map(7'd0, 7'd127, 7'd0, 7'd127);
        send_word(CMD_WRITE, 2, 0, 500);              // outside map, ignored
        send_word(CMD_READ, 2, 0, 0);
        send_word(CMD_WRITE, 0, 0, 1000);
        send_word(CMD_WRITE, 1, 40, 60000);           // no right neighbor on row 1
        send_word(CMD_FILL, 0, 0, 0);
        send_word(CMD_READ, 0, 63, 0);
        send_word(CMD_READ, 1, 20, 0);
        send_word(CMD_READ, 1, 63, 0);
        drain();
        quiet = 1'b0;

        set_map(7'd3, 7'd2, 7'd1, 7'd1);
        random_job();
        set_map(7'd64, 7'd5, 7'd63, 7'd2);
        random_job();

        // Mostly small maps so fills stay short.
        for (int j = 0; j < 5; j++) begin
            quiet = (j == 3);
            if ($urandom_range(3) == 0)
                set_map($urandom_range(127), $urandom_range(127) % 13,
                        $urandom_range(127), $urandom_range(127));
            else
                set_map($urandom_range(2, 12), $urandom_range(2, 12),
                        $urandom_range(1, 6), $urandom_range(1, 6));
            random_job();
        end
        quiet = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        if (grid.errors == 0 && grid.pending.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/bgf_pkg.sv
rtl/bgf_lerp.sv
rtl/bilinear_grid_fill_unit.sv
rtl/bgf_checker.sv
dv/tb.sv
